// ===== design/inversion_pair_counter_macros.svh =====
// ----------------------------------------------------------------------------
// Inversion pair counter assertion macros
// Shorthand for the clocked, reset-gated assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INVERSION_PAIR_COUNTER_MACROS_SVH
`define INVERSION_PAIR_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define IPC_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ipc assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define IPC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ipc assertion failed");

`endif

// ===== design/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// Inversion pair counter package
// Token type that travels down the cell chain and the order key helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipc_pkg;

	localparam int KEY_W   = 32;
	localparam int INV_W   = 11;
	localparam int ELEM_W  = 7;
	localparam int INV_SAT = 2047;
	localparam int CNT_SAT = 127;

	// One element in flight along the chain.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             stored;
		logic [KEY_W-1:0] key;
	} ipc_tok_t;

	// Flipping the sign bit makes unsigned order match two's complement order.
	function automatic logic [KEY_W-1:0] ipc_order_key(input logic [KEY_W-1:0] raw);
		ipc_order_key = {~raw[KEY_W-1], raw[KEY_W-2:0]};
	endfunction

endpackage

// ===== design/ipc_cell.sv =====
// ----------------------------------------------------------------------------
// Inversion pair counter cell
// Holds one stored element, counts a passing element it exceeds, and
// captures the first element of a sequence that finds it empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipc_cell #(
	parameter int CW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ipc_pkg::ipc_tok_t tok_in,
	input  logic [CW-1:0]     cnt_in,
	output ipc_pkg::ipc_tok_t tok_out,
	output logic [CW-1:0]     cnt_out
);
	import ipc_pkg::*;

	logic             occ_q;
	logic [KEY_W-1:0] val_q;
	ipc_tok_t         tok_q;
	logic [CW-1:0]    cnt_q;
	logic             greater;
	logic             take;

	assign greater = tok_in.valid && occ_q && (val_q > tok_in.key);
	assign take    = tok_in.valid && !tok_in.stored && !occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			tok_q <= '0;
		end else if (adv) begin
			// The last element of a sequence empties every cell it passes.
			if (tok_in.valid && tok_in.last) begin
				occ_q <= 1'b0;
			end else if (take) begin
				occ_q <= 1'b1;
			end
			tok_q <= '{valid: tok_in.valid, last: tok_in.last,
			           stored: tok_in.stored | take, key: tok_in.key};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take) begin
				val_q <= tok_in.key;
			end
			cnt_q <= cnt_in + CW'(greater);
		end
	end

	assign tok_out = tok_q;
	assign cnt_out = cnt_q;

endmodule

// ===== design/ipc_tally.sv =====
// ----------------------------------------------------------------------------
// Inversion pair counter tally
// Sums the counts of elements leaving the chain and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipc_tally #(
	parameter int MAX_LEN = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  ipc_pkg::ipc_tok_t              tail_tok,
	input  logic [$clog2(MAX_LEN+1)-1:0]   tail_cnt,
	input  logic                           res_ready,
	output logic                           res_valid,
	output logic [ipc_pkg::INV_W-1:0]      inversion_total,
	output logic [ipc_pkg::ELEM_W-1:0]     element_total,
	output logic                           overflowed
);
	import ipc_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int SW = ((CW > INV_W) ? CW : INV_W) + 1;
	localparam int EW = (CW > ELEM_W) ? CW : ELEM_W;

	logic [INV_W-1:0] acc_q;
	logic [CW-1:0]    num_q;
	logic             ovf_q;
	logic             res_valid_q;
	logic [SW-1:0]    sum;
	logic [INV_W-1:0] acc_next;
	logic [CW-1:0]    num_next;
	logic [EW-1:0]    num_ext;
	logic             ovf_next;
	logic             take;

	assign take     = adv && tail_tok.valid;
	assign sum      = SW'(acc_q) + SW'(tail_cnt);
	// A dropped element contributes nothing to the total.
	assign acc_next = !tail_tok.stored ? acc_q :
	                  (sum > SW'(INV_SAT)) ? INV_W'(INV_SAT) : sum[INV_W-1:0];
	assign num_next = num_q + CW'(tail_tok.stored);
	assign num_ext  = EW'(num_next);
	assign ovf_next = ovf_q | !tail_tok.stored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			num_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take && tail_tok.last) begin
				acc_q       <= '0;
				num_q       <= '0;
				ovf_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else begin
				if (take) begin
					acc_q <= acc_next;
					num_q <= num_next;
					ovf_q <= ovf_next;
				end
				if (res_ready) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && tail_tok.last) begin
			inversion_total <= acc_next;
			element_total   <= (num_ext > EW'(CNT_SAT)) ? ELEM_W'(CNT_SAT) :
			                   num_ext[ELEM_W-1:0];
			overflowed      <= ovf_next;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ===== design/inversion_pair_counter.sv =====
// A result item is registered in the tally after its last element has passed through every cell of the row.
// Throughput: one element per cycle while the row advances; each element walks the cell row one cell a cycle.
// The row stalls only while a result item waits and another last element reaches the end.
// Reset (arst_n low, asynchronous) empties every cell and clears the running totals and output valid.
// ----------------------------------------------------------------------------
// Inversion pair counter top level
// Streams signed elements through a row of compare cells and reports the
// number of inversion pairs, the element count and an overflow flag per run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inversion_pair_counter #(
	parameter int MAX_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] element_value
	input  logic        s_tlast,   // last_element
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [10:0] inversion_total, [17:11] element_total, rest 0
	output logic        m_tuser    // [0] overflowed
);
	import ipc_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	// Token and running count at each boundary of the cell row. Boundary zero
	// is the incoming element; boundary MAX_LEN leaves the last cell.
	ipc_tok_t         tok [MAX_LEN+1];
	logic [CW-1:0]    cnt [MAX_LEN+1];
	logic             adv;
	logic             res_valid;
	logic [INV_W-1:0] inv_total;
	logic [ELEM_W-1:0] elem_total;
	logic             ovf;

	// The whole row moves together. It holds only when the element leaving
	// the last cell would produce a result while the previous one is still
	// waiting; elements that produce no result keep flowing.
	assign adv = !(tok[MAX_LEN].valid && tok[MAX_LEN].last) || !res_valid || m_tready;

	assign s_tready = adv;

	// A new element enters not yet stored and with nothing counted.
	assign tok[0] = '{valid: s_tvalid, last: s_tlast, stored: 1'b0,
	                  key: ipc_order_key(s_tdata)};
	assign cnt[0] = '0;

	// Cells fill in arrival order, so an element meets every earlier element
	// of its run in the cells ahead of the first empty one, which it takes.
	for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
		ipc_cell #(
			.CW(CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_in (tok[g]),
			.cnt_in (cnt[g]),
			.tok_out(tok[g+1]),
			.cnt_out(cnt[g+1])
		);
	end

	// The tally adds up the counts of stored elements and flags any element
	// that found the row full; the last element of a run emits the result.
	ipc_tally #(
		.MAX_LEN(MAX_LEN)
	) u_tally (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.tail_tok       (tok[MAX_LEN]),
		.tail_cnt       (cnt[MAX_LEN]),
		.res_ready      (m_tready),
		.res_valid      (res_valid),
		.inversion_total(inv_total),
		.element_total  (elem_total),
		.overflowed     (ovf)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = {6'd0, elem_total, inv_total};
	assign m_tuser  = ovf;

endmodule

// ===== design/ipc_checker.sv =====
// ----------------------------------------------------------------------------
// Inversion pair counter port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "inversion_pair_counter_macros.svh"

module ipc_checker #(
	parameter int MAX_LEN = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);
	localparam int CAP = (MAX_LEN > 127) ? 127 : MAX_LEN;

	// A waiting result item stays up.
	`IPC_ASSERT_NEXT(a_res_holds, m_tvalid && !m_tready, m_tvalid)
	// Input is refused only while a result item waits unaccepted.
	`IPC_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)
	// A run of at most one element has no inversions.
	`IPC_ASSERT_NOW(a_short_run, m_tvalid && (m_tdata[17:11] <= 7'd1), m_tdata[10:0] == 11'd0)
	// An overflowed run filled every cell.
	`IPC_ASSERT_NOW(a_ovf_full, m_tvalid && m_tuser, m_tdata[17:11] == 7'(CAP))

endmodule

bind inversion_pair_counter ipc_checker #(
	.MAX_LEN(MAX_LEN)
) u_ipc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
